[design/kwm_pkg.sv]
// kwm_pkg: shared types and constants of the k-way merge heap.
// Depends on nothing; kwm_less and k_way_merge_heap import it.
package kwm_pkg;

    // Source numbers are a fixed 4-bit field.
    localparam int SRC_W = 4;

    // Item operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Heap controller states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_UP_C = 6'b000010,
        S_LAST = 6'b000100,
        S_DN_R = 6'b001000,
        S_DN_C = 6'b010000,
        S_PUT  = 6'b100000
    } kwm_state_t;

endpackage

[design/kwm_ram.sv]
// kwm_ram: generic single-write, single-read synchronous RAM, registered read.
// Depends on nothing.
module kwm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/kwm_less.sv]
// kwm_less: heap ordering of two entries (signed key, then lower source first).
// Depends on kwm_pkg.
module kwm_less
    import kwm_pkg::*;
#(
    parameter int KEY_BITS = 32
) (
    input  logic signed [KEY_BITS-1:0] a_key,
    input  logic        [SRC_W-1:0]    a_src,
    input  logic signed [KEY_BITS-1:0] b_key,
    input  logic        [SRC_W-1:0]    b_src,
    output logic                       lt
);

    // Break key ties on source number.
    assign lt = (a_key < b_key) || ((a_key == b_key) && (a_src < b_src));

endmodule

[design/k_way_merge_heap.sv]
// k_way_merge_heap: top level of the k-way merge min-heap.
// Depends on kwm_pkg, kwm_ram and kwm_less.
//
// Merges up to MAX_SOURCES sorted streams. Issue an item with start while busy
// is low: op = load inserts a source's head key (key, source); op = pop removes
// the smallest entry and, with has_next, replaces it by key from the same
// source, else the last entry takes the root. Each item yields exactly one
// result, shown for a single cycle with done high; the receiver cannot stall,
// so capture it then. top_source names the source whose next key the following
// pop needs; error flags a pop on an empty heap or a load into a full heap.
// Entries live in one RAM with a registered read; the root is also
// held in registers so a pop finds the minimum without a read. A pop sifts
// down through S_DN_R and S_DN_C for each heap level, after S_LAST fetches the
// last entry when there is no next key; a load climbs through S_UP_C. Both end
// in S_PUT. The slowest item is a pop without a next key, set by the
// read-compare loop of the sift-down. Errors and pops that empty the heap
// finish without leaving S_IDLE.
module k_way_merge_heap
    import kwm_pkg::*;
#(
    parameter int MAX_SOURCES = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       op,
    input  logic signed [KEY_BITS-1:0] key,
    input  logic        [SRC_W-1:0]    source,
    input  logic                       has_next,
    output logic                       done,
    output logic signed [KEY_BITS-1:0] popped_key,
    output logic                       popped_valid,
    output logic        [SRC_W-1:0]    popped_source,
    output logic        [SRC_W-1:0]    top_source,
    output logic                       heap_empty,
    output logic                       error
);

    localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam int EXT_W = IDX_W + 2;
    localparam int ENT_W = KEY_BITS + SRC_W;

    // Controller state.
    kwm_state_t state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           hole_reg, hole_next;
    logic signed [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [SRC_W-1:0]           cur_src_reg, cur_src_next;
    logic [ENT_W-1:0]           lft_reg, lft_next;
    logic                       has_right_reg, has_right_next;
    logic signed [KEY_BITS-1:0] root_key_reg, root_key_next;
    logic [SRC_W-1:0]           root_src_reg, root_src_next;

    // Result registers.
    logic                       done_reg, done_next;
    logic signed [KEY_BITS-1:0] pkey_reg, pkey_next;
    logic                       pvalid_reg, pvalid_next;
    logic [SRC_W-1:0]           psrc_reg, psrc_next;
    logic [SRC_W-1:0]           top_reg, top_next;
    logic                       empty_reg, empty_next;
    logic                       err_reg, err_next;

    // RAM port.
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;

    kwm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SOURCES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Split the stored entries.
    logic signed [KEY_BITS-1:0] rd_key, lft_key;
    logic [SRC_W-1:0]           rd_src, lft_src;

    assign rd_key  = ram_rdata[ENT_W-1:SRC_W];
    assign rd_src  = ram_rdata[SRC_W-1:0];
    assign lft_key = lft_reg[ENT_W-1:SRC_W];
    assign lft_src = lft_reg[SRC_W-1:0];

    // Comparators: all three sift-down orderings in parallel, plus sift-up.
    logic l_lt_cur, r_lt_l, r_lt_cur, cur_lt_rd;

    kwm_less #(.KEY_BITS(KEY_BITS)) u_less_lc (
        .a_key (lft_key), .a_src (lft_src),
        .b_key (cur_key_reg), .b_src (cur_src_reg),
        .lt    (l_lt_cur)
    );

    kwm_less #(.KEY_BITS(KEY_BITS)) u_less_rl (
        .a_key (rd_key), .a_src (rd_src),
        .b_key (lft_key), .b_src (lft_src),
        .lt    (r_lt_l)
    );

    kwm_less #(.KEY_BITS(KEY_BITS)) u_less_rc (
        .a_key (rd_key), .a_src (rd_src),
        .b_key (cur_key_reg), .b_src (cur_src_reg),
        .lt    (r_lt_cur)
    );

    kwm_less #(.KEY_BITS(KEY_BITS)) u_less_up (
        .a_key (cur_key_reg), .a_src (cur_src_reg),
        .b_key (rd_key), .b_src (rd_src),
        .lt    (cur_lt_rd)
    );

    // Index arithmetic around the hole.
    logic [EXT_W-1:0] cnt_ext, lidx, ridx, nl_idx;
    logic [IDX_W-1:0] parent_idx, cnt_parent, pick_idx;
    logic             pick_right, descend;

    assign cnt_ext    = EXT_W'(count_reg);
    assign lidx       = EXT_W'({hole_reg, 1'b1});
    assign ridx       = lidx + EXT_W'(1);
    assign parent_idx = IDX_W'((hole_reg - IDX_W'(1)) >> 1);
    assign cnt_parent = IDX_W'((count_reg[IDX_W-1:0] - IDX_W'(1)) >> 1);
    assign pick_right = has_right_reg && r_lt_l;
    assign pick_idx   = pick_right ? ridx[IDX_W-1:0] : lidx[IDX_W-1:0];
    assign descend    = pick_right ? r_lt_cur : l_lt_cur;
    assign nl_idx     = EXT_W'({pick_idx, 1'b1});

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        hole_next      = hole_reg;
        cur_key_next   = cur_key_reg;
        cur_src_next   = cur_src_reg;
        lft_next       = lft_reg;
        has_right_next = has_right_reg;
        done_next      = 1'b0;
        pkey_next      = pkey_reg;
        pvalid_next    = pvalid_reg;
        psrc_next      = psrc_reg;
        top_next       = top_reg;
        empty_next     = empty_reg;
        err_next       = err_reg;
        ram_we         = 1'b0;
        ram_waddr      = hole_reg;
        ram_wdata      = {cur_key_reg, cur_src_reg};
        ram_re         = 1'b0;
        ram_raddr      = hole_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pkey_next   = '0;
                    pvalid_next = 1'b0;
                    psrc_next   = '0;
                    err_next    = 1'b0;
                    if (op == OP_LOAD)
                    begin
                        if (count_reg == CNT_W'(MAX_SOURCES))
                        begin
                            // Full: report and drop the item.
                            err_next   = 1'b1;
                            done_next  = 1'b1;
                            top_next   = root_src_reg;
                            empty_next = 1'b0;
                        end
                        else
                        begin
                            cur_key_next = key;
                            cur_src_next = source;
                            hole_next    = count_reg[IDX_W-1:0];
                            count_next   = count_reg + CNT_W'(1);
                            if (count_reg == '0)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = cnt_parent;
                                state_next = S_UP_C;
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // Pop on empty heap.
                        err_next   = 1'b1;
                        done_next  = 1'b1;
                        top_next   = '0;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        pkey_next   = root_key_reg;
                        psrc_next   = root_src_reg;
                        pvalid_next = 1'b1;
                        hole_next   = '0;
                        if (has_next)
                        begin
                            cur_key_next = key;
                            cur_src_next = root_src_reg;
                            if (count_reg > CNT_W'(1))
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = IDX_W'(1);
                                state_next = S_DN_R;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                            if (count_reg == CNT_W'(1))
                            begin
                                // Last entry gone: report an empty heap.
                                done_next  = 1'b1;
                                top_next   = '0;
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                // Fetch the last entry to refill the root.
                                ram_re     = 1'b1;
                                ram_raddr  = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_LAST;
                            end
                        end
                    end
                end
            end

            S_UP_C:
            begin
                // Parent data is on the read port.
                if (cur_lt_rd)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = hole_reg;
                    ram_wdata = ram_rdata;
                    hole_next = parent_idx;
                    if (parent_idx == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = IDX_W'((parent_idx - IDX_W'(1)) >> 1);
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_LAST:
            begin
                cur_key_next = rd_key;
                cur_src_next = rd_src;
                if (count_reg > CNT_W'(1))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = IDX_W'(1);
                    state_next = S_DN_R;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_DN_R:
            begin
                // Hold the left child, fetch the right one if present.
                lft_next       = ram_rdata;
                has_right_next = (ridx < cnt_ext);
                if (ridx < cnt_ext)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ridx[IDX_W-1:0];
                end
                state_next = S_DN_C;
            end

            S_DN_C:
            begin
                if (descend)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = hole_reg;
                    ram_wdata = pick_right ? ram_rdata : lft_reg;
                    hole_next = pick_idx;
                    if (nl_idx < cnt_ext)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = nl_idx[IDX_W-1:0];
                        state_next = S_DN_R;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                // Drop the carried entry into the hole and report.
                ram_we     = 1'b1;
                ram_waddr  = hole_reg;
                ram_wdata  = {cur_key_reg, cur_src_reg};
                done_next  = 1'b1;
                top_next   = (hole_reg == '0) ? cur_src_reg : root_src_reg;
                empty_next = 1'b0;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Mirror every write to the root in registers.
    always_comb
    begin
        root_key_next = root_key_reg;
        root_src_next = root_src_reg;
        if (ram_we && (ram_waddr == '0))
        begin
            root_key_next = ram_wdata[ENT_W-1:SRC_W];
            root_src_next = ram_wdata[SRC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg      <= hole_next;
        cur_key_reg   <= cur_key_next;
        cur_src_reg   <= cur_src_next;
        lft_reg       <= lft_next;
        has_right_reg <= has_right_next;
        root_key_reg  <= root_key_next;
        root_src_reg  <= root_src_next;
        pkey_reg      <= pkey_next;
        pvalid_reg    <= pvalid_next;
        psrc_reg      <= psrc_next;
        top_reg       <= top_next;
        empty_reg     <= empty_next;
        err_reg       <= err_next;
    end

    assign done          = done_reg;
    assign popped_key    = pkey_reg;
    assign popped_valid  = pvalid_reg;
    assign popped_source = psrc_reg;
    assign top_source    = top_reg;
    assign heap_empty    = empty_reg;
    assign error         = err_reg;

endmodule
